/* hdl/ocp_pkg.sv */
// Shared constants, types and a helper function for the orbit camera position core.
// Holds the angle format, the CORDIC arctangent table and the interface structs.
// No dependencies.
package ocp_pkg;

    localparam int ANGLE_BITS        = 16;
    localparam int PITCH_W           = 15;
    localparam int DIST_W            = 31;
    localparam int COORD_W           = 32;
    localparam int RATE_W            = 16;
    localparam int TIME_W            = 16;
    localparam int CORDIC_W          = 32;
    localparam int ATAN_LEN          = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // (pi/2 - 0.1) rad in binary-angle units
    localparam logic signed [PITCH_W-1:0]  PITCH_LIMIT = 15'sd15341;
    // CORDIC start vector, gain compensation in Q30
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic [DIST_W-1:0]          DIST_RESET  = 31'd65536;

    // atan(2^-i) in Q0.32 turns, truncated
    localparam logic [CORDIC_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef enum logic [1:0] {
        CFG_DISTANCE    = 2'd0,
        CFG_START_YAW   = 2'd1,
        CFG_START_PITCH = 2'd2
    } ocp_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_ANGLE,
        ST_LAUNCH,
        ST_ROTATE,
        ST_MULT,
        ST_HOLD
    } ocp_state_t;

    // Steps of the shared distance multiplier.
    typedef enum logic [2:0] {
        MS_DCP,
        MS_PY,
        MS_PX,
        MS_PZ,
        MS_FIN
    } ocp_mstep_t;

    typedef struct packed {
        logic                       flip;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } ocp_vec_t;

    typedef struct packed {
        ocp_vec_t yaw;
        ocp_vec_t pitch;
    } ocp_rot_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic update;
    } ocp_ang_ctl_t;

    typedef struct packed {
        logic                  yaw_we;
        logic                  pitch_we;
        logic [ANGLE_BITS-1:0] data;
    } ocp_cfg_wr_t;

    typedef struct packed {
        logic start;
        logic load;
    } ocp_mul_ctl_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } ocp_mul_sts_t;

    // Map a binary angle into the CORDIC range; fold the left half-plane by half a turn.
    function automatic ocp_vec_t cordic_seed(input logic [ANGLE_BITS-1:0] ang);
        logic [CORDIC_W-1:0] a;
        ocp_vec_t            v;
        a      = {ang, {(CORDIC_W-ANGLE_BITS){1'b0}}};
        v.flip = a[CORDIC_W-1] ^ a[CORDIC_W-2];
        v.x    = CORDIC_GAIN;
        v.y    = '0;
        v.z    = v.flip ? {~a[CORDIC_W-1], a[CORDIC_W-2:0]} : a;
        return v;
    endfunction

endpackage

/* hdl/ocp_angle.sv */
// Yaw and pitch angle state with the per-frame angle step and pitch clamp.
// Depends on ocp_pkg.
module ocp_angle (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ocp_pkg::ocp_ang_ctl_t                ctl,
    input  ocp_pkg::ocp_cfg_wr_t                 cfg,
    input  logic signed [ocp_pkg::RATE_W-1:0]    yaw_rate,
    input  logic signed [ocp_pkg::RATE_W-1:0]    pitch_rate,
    input  logic [ocp_pkg::TIME_W-1:0]           frame_time,
    output logic [ocp_pkg::ANGLE_BITS-1:0]       yaw,
    output logic signed [ocp_pkg::PITCH_W-1:0]   pitch
);

    localparam int PROD_W = ocp_pkg::RATE_W + ocp_pkg::TIME_W + 1;
    localparam int STEP_W = ocp_pkg::RATE_W + 1;
    localparam int DIFF_W = ocp_pkg::PITCH_W + 3;
    localparam logic signed [PROD_W-1:0] STEP_HALF = PROD_W'(1) << (ocp_pkg::TIME_W - 1);
    localparam logic signed [DIFF_W-1:0] LIMIT_EXT = DIFF_W'(ocp_pkg::PITCH_LIMIT);

    logic signed [ocp_pkg::RATE_W-1:0]  yrate_reg, prate_reg;
    logic [ocp_pkg::TIME_W-1:0]         ft_reg;
    logic signed [STEP_W-1:0]           dy_reg, dp_reg;
    logic [ocp_pkg::ANGLE_BITS-1:0]     yaw_reg, yaw_next;
    logic signed [ocp_pkg::PITCH_W-1:0] pitch_reg, pitch_next;

    logic signed [PROD_W-1:0] prod_y, prod_p, rnd_y, rnd_p;
    logic signed [DIFF_W-1:0] diff;

    function automatic logic signed [ocp_pkg::PITCH_W-1:0] clamp(input logic signed [DIFF_W-1:0] p);
        logic signed [ocp_pkg::PITCH_W-1:0] r;
        if (p > LIMIT_EXT) begin
            r = ocp_pkg::PITCH_LIMIT;
        end else if (p < -LIMIT_EXT) begin
            r = -ocp_pkg::PITCH_LIMIT;
        end else begin
            r = p[ocp_pkg::PITCH_W-1:0];
        end
        return r;
    endfunction

    // Angle step: rate * time in Q.16, rounded half up.
    always_comb begin
        prod_y = yrate_reg * $signed({1'b0, ft_reg});
        prod_p = prate_reg * $signed({1'b0, ft_reg});
        rnd_y  = prod_y + STEP_HALF;
        rnd_p  = prod_p + STEP_HALF;
        diff   = DIFF_W'(pitch_reg) - DIFF_W'(dp_reg);
    end

    always_comb begin
        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        priority if (cfg.yaw_we || cfg.pitch_we) begin
            if (cfg.yaw_we) begin
                yaw_next = cfg.data;
            end
            if (cfg.pitch_we) begin
                pitch_next = clamp(DIFF_W'($signed(cfg.data[ocp_pkg::PITCH_W-1:0])));
            end
        end else if (ctl.update) begin
            yaw_next   = yaw_reg + dy_reg[ocp_pkg::ANGLE_BITS-1:0];
            pitch_next = clamp(diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end else begin
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            yrate_reg <= yaw_rate;
            prate_reg <= pitch_rate;
            ft_reg    <= frame_time;
        end
        if (ctl.step) begin
            dy_reg <= rnd_y[PROD_W-1:ocp_pkg::TIME_W];
            dp_reg <= rnd_p[PROD_W-1:ocp_pkg::TIME_W];
        end
    end

    assign yaw   = yaw_reg;
    assign pitch = pitch_reg;

endmodule

/* hdl/ocp_rot_cell.sv */
// One CORDIC rotation cell: advances the yaw and pitch vectors by one micro-rotation.
// Depends on ocp_pkg for the vector type and the arctangent table.
module ocp_rot_cell #(
    parameter int SHIFT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_vld,
    input  ocp_pkg::ocp_rot_t in_data,
    output logic              out_vld,
    output ocp_pkg::ocp_rot_t out_data
);

    localparam int W = ocp_pkg::CORDIC_W;
    localparam logic signed [W-1:0] ATAN = ocp_pkg::ATAN_TURNS[SHIFT];

    logic              vld_reg;
    ocp_pkg::ocp_rot_t data_reg, data_next;

    function automatic ocp_pkg::ocp_vec_t rotate(input ocp_pkg::ocp_vec_t v);
        logic signed [W-1:0] xs, ys, zs, dx, dy;
        ocp_pkg::ocp_vec_t   r;
        xs     = v.x;
        ys     = v.y;
        zs     = v.z;
        dx     = ys >>> SHIFT;
        dy     = xs >>> SHIFT;
        r.flip = v.flip;
        if (!zs[W-1]) begin
            r.x = xs - dx;
            r.y = ys + dy;
            r.z = zs - ATAN;
        end else begin
            r.x = xs + dx;
            r.y = ys - dy;
            r.z = zs + ATAN;
        end
        return r;
    endfunction

    always_comb begin
        data_next.yaw   = rotate(in_data.yaw);
        data_next.pitch = rotate(in_data.pitch);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

/* hdl/ocp_product.sv */
// Distance products on one shared multiplier, rounding, saturating sums and the result register.
// Depends on ocp_pkg.
module ocp_product (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ocp_pkg::ocp_mul_ctl_t                ctl,
    output ocp_pkg::ocp_mul_sts_t                sts,
    input  ocp_pkg::ocp_rot_t                    rot,
    input  logic [ocp_pkg::DIST_W-1:0]           distance,
    input  logic signed [ocp_pkg::COORD_W-1:0]   tgt_x,
    input  logic signed [ocp_pkg::COORD_W-1:0]   tgt_y,
    input  logic signed [ocp_pkg::COORD_W-1:0]   tgt_z,
    input  logic [ocp_pkg::ANGLE_BITS-1:0]       yaw,
    input  logic signed [ocp_pkg::PITCH_W-1:0]   pitch,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ocp_pkg::COORD_W-1:0]   m_pos_x,
    output logic signed [ocp_pkg::COORD_W-1:0]   m_pos_y,
    output logic signed [ocp_pkg::COORD_W-1:0]   m_pos_z,
    output logic [ocp_pkg::ANGLE_BITS-1:0]       m_cur_yaw,
    output logic signed [ocp_pkg::PITCH_W-1:0]   m_cur_pitch
);

    localparam int CW     = ocp_pkg::CORDIC_W;
    localparam int FRAC   = 30;
    localparam int DCP_W  = ocp_pkg::DIST_W + 2;
    localparam int A_W    = DCP_W + 1;
    localparam int P_W    = A_W + CW;
    localparam int TERM_W = A_W;
    localparam int SUM_W  = TERM_W + 1;
    localparam int OW     = ocp_pkg::COORD_W;
    localparam logic signed [P_W-1:0] HALF = P_W'(1) << (FRAC - 1);

    logic                busy_reg, busy_next;
    ocp_pkg::ocp_mstep_t step_reg, step_next;
    logic                m_valid_reg, m_valid_next;

    logic signed [CW-1:0]     sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [DCP_W-1:0]  dcp_reg;
    logic signed [TERM_W-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [OW-1:0]     px_reg, py_reg, pz_reg;
    logic [ocp_pkg::ANGLE_BITS-1:0]     cyaw_reg;
    logic signed [ocp_pkg::PITCH_W-1:0] cpitch_reg;

    logic signed [A_W-1:0] a_op;
    logic signed [CW-1:0]  b_op;
    logic signed [P_W-1:0] prod_next, rnd;

    function automatic logic signed [OW-1:0] sat_add(input logic signed [OW-1:0] t,
                                                     input logic signed [TERM_W-1:0] d);
        logic signed [SUM_W-1:0] s;
        logic signed [OW-1:0]    r;
        s = SUM_W'(t) + SUM_W'(d);
        if (s[SUM_W-1:OW-1] == '0 || s[SUM_W-1:OW-1] == '1) begin
            r = s[OW-1:0];
        end else if (s[SUM_W-1]) begin
            r = {1'b1, {(OW-1){1'b0}}};
        end else begin
            r = {1'b0, {(OW-1){1'b1}}};
        end
        return r;
    endfunction

    // Operand select for the shared multiplier.
    always_comb begin
        unique case (step_reg)
            ocp_pkg::MS_DCP: begin
                a_op = $signed({{(A_W-ocp_pkg::DIST_W){1'b0}}, distance});
                b_op = cp_reg;
            end
            ocp_pkg::MS_PY: begin
                a_op = $signed({{(A_W-ocp_pkg::DIST_W){1'b0}}, distance});
                b_op = sp_reg;
            end
            ocp_pkg::MS_PX: begin
                a_op = A_W'(dcp_reg);
                b_op = sy_reg;
            end
            ocp_pkg::MS_PZ: begin
                a_op = A_W'(dcp_reg);
                b_op = cy_reg;
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
        prod_next = a_op * b_op;
        rnd       = prod_reg + HALF;
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            step_next = ocp_pkg::MS_DCP;
        end else if (busy_reg) begin
            unique case (step_reg)
                ocp_pkg::MS_DCP: step_next = ocp_pkg::MS_PY;
                ocp_pkg::MS_PY:  step_next = ocp_pkg::MS_PX;
                ocp_pkg::MS_PX:  step_next = ocp_pkg::MS_PZ;
                ocp_pkg::MS_PZ:  step_next = ocp_pkg::MS_FIN;
                default:         busy_next = 1'b0;
            endcase
        end

        m_valid_next = m_valid_reg;
        if (ctl.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= ocp_pkg::MS_DCP;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            // Undo the half-turn fold.
            sy_reg <= rot.yaw.flip   ? -rot.yaw.y   : rot.yaw.y;
            cy_reg <= rot.yaw.flip   ? -rot.yaw.x   : rot.yaw.x;
            sp_reg <= rot.pitch.flip ? -rot.pitch.y : rot.pitch.y;
            cp_reg <= rot.pitch.flip ? -rot.pitch.x : rot.pitch.x;
        end
        if (busy_reg) begin
            prod_reg <= prod_next;
            unique case (step_reg)
                ocp_pkg::MS_PY:  dcp_reg <= rnd[FRAC+DCP_W-1:FRAC];
                ocp_pkg::MS_PX:  ty_reg  <= rnd[FRAC+TERM_W-1:FRAC];
                ocp_pkg::MS_PZ:  tx_reg  <= rnd[FRAC+TERM_W-1:FRAC];
                ocp_pkg::MS_FIN: tz_reg  <= rnd[FRAC+TERM_W-1:FRAC];
                default: ;
            endcase
        end
        if (ctl.load) begin
            px_reg     <= sat_add(tgt_x, tx_reg);
            py_reg     <= sat_add(tgt_y, ty_reg);
            pz_reg     <= sat_add(tgt_z, tz_reg);
            cyaw_reg   <= yaw;
            cpitch_reg <= pitch;
        end
    end

    assign sts.done     = busy_reg && (step_reg == ocp_pkg::MS_FIN);
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_pos_x     = px_reg;
    assign m_pos_y     = py_reg;
    assign m_pos_z     = pz_reg;
    assign m_cur_yaw   = cyaw_reg;
    assign m_cur_pitch = cpitch_reg;

endmodule

/* hdl/orbit_camera_position_core.sv */
// Orbit camera position core. Per frame item: yaw advances by rate * time and wraps at one
// turn, pitch falls by rate * time and is clamped to +-15341 units ((pi/2 - 0.1) rad), then the
// camera position target + distance * (cos p sin y, sin p, cos p cos y) is produced, saturated
// to Q16.16. Sine and cosine of both angles come from one chain of CORDIC_STAGES rotation cells;
// the four distance products share one multiplier. One item is in flight at a time; it passes
// the angle step, update and launch, the rotation chain, five multiplier steps and the load
// into the result register, in that order, waiting before that load while the result register
// is still full. A result waiting in the result register does not block acceptance of the next
// item. cfg_ready is always high; write the configuration registers only while no item is in
// flight. Writing start_yaw or start_pitch loads the live angle at once.
// Depends on ocp_pkg, ocp_angle, ocp_rot_cell and ocp_product.
module orbit_camera_position_core #(
    parameter int CORDIC_STAGES = ocp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ocp_pkg::COORD_W-1:0]   s_target_x,
    input  logic signed [ocp_pkg::COORD_W-1:0]   s_target_y,
    input  logic signed [ocp_pkg::COORD_W-1:0]   s_target_z,
    input  logic signed [ocp_pkg::RATE_W-1:0]    s_yaw_rate,
    input  logic signed [ocp_pkg::RATE_W-1:0]    s_pitch_rate,
    input  logic [ocp_pkg::TIME_W-1:0]           s_frame_time,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ocp_pkg::COORD_W-1:0]   m_pos_x,
    output logic signed [ocp_pkg::COORD_W-1:0]   m_pos_y,
    output logic signed [ocp_pkg::COORD_W-1:0]   m_pos_z,
    output logic [ocp_pkg::ANGLE_BITS-1:0]       m_cur_yaw,
    output logic signed [ocp_pkg::PITCH_W-1:0]   m_cur_pitch,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [ocp_pkg::COORD_W-1:0]          cfg_data
);

    ocp_pkg::ocp_state_t state_reg, state_next;

    logic [ocp_pkg::DIST_W-1:0]          dist_reg, dist_next;
    logic signed [ocp_pkg::COORD_W-1:0]  tx_reg, ty_reg, tz_reg;

    ocp_pkg::ocp_ang_ctl_t ang_ctl;
    ocp_pkg::ocp_cfg_wr_t  cfg_wr;
    ocp_pkg::ocp_mul_ctl_t mul_ctl;
    ocp_pkg::ocp_mul_sts_t mul_sts;

    logic [ocp_pkg::ANGLE_BITS-1:0]     yaw;
    logic signed [ocp_pkg::PITCH_W-1:0] pitch;

    logic [CORDIC_STAGES:0] rot_v;
    ocp_pkg::ocp_rot_t      rot_d [CORDIC_STAGES+1];

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ocp_pkg::ST_IDLE);

    // Configuration decode; unknown indexes are dropped.
    always_comb begin
        dist_next       = dist_reg;
        cfg_wr.yaw_we   = 1'b0;
        cfg_wr.pitch_we = 1'b0;
        cfg_wr.data     = cfg_data[ocp_pkg::ANGLE_BITS-1:0];
        if (cfg_valid) begin
            unique case (cfg_index)
                ocp_pkg::CFG_DISTANCE:    dist_next = cfg_data[ocp_pkg::DIST_W-1:0];
                ocp_pkg::CFG_START_YAW:   cfg_wr.yaw_we = 1'b1;
                ocp_pkg::CFG_START_PITCH: cfg_wr.pitch_we = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        ang_ctl.capture = 1'b0;
        ang_ctl.step    = 1'b0;
        ang_ctl.update  = 1'b0;
        mul_ctl.start   = 1'b0;
        mul_ctl.load    = 1'b0;
        unique case (state_reg)
            ocp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    ang_ctl.capture = 1'b1;
                    state_next      = ocp_pkg::ST_STEP;
                end
            end
            ocp_pkg::ST_STEP: begin
                ang_ctl.step = 1'b1;
                state_next   = ocp_pkg::ST_ANGLE;
            end
            ocp_pkg::ST_ANGLE: begin
                ang_ctl.update = 1'b1;
                state_next     = ocp_pkg::ST_LAUNCH;
            end
            ocp_pkg::ST_LAUNCH: begin
                state_next = ocp_pkg::ST_ROTATE;
            end
            ocp_pkg::ST_ROTATE: begin
                if (rot_v[CORDIC_STAGES]) begin
                    mul_ctl.start = 1'b1;
                    state_next    = ocp_pkg::ST_MULT;
                end
            end
            ocp_pkg::ST_MULT: begin
                if (mul_sts.done) begin
                    state_next = ocp_pkg::ST_HOLD;
                end
            end
            ocp_pkg::ST_HOLD: begin
                // Hold until the result register can take the item.
                if (mul_sts.out_free) begin
                    mul_ctl.load = 1'b1;
                    state_next   = ocp_pkg::ST_IDLE;
                end
            end
            default: state_next = ocp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ocp_pkg::ST_IDLE;
            dist_reg  <= ocp_pkg::DIST_RESET;
        end else begin
            state_reg <= state_next;
            dist_reg  <= dist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ang_ctl.capture) begin
            tx_reg <= s_target_x;
            ty_reg <= s_target_y;
            tz_reg <= s_target_z;
        end
    end

    ocp_angle u_angle (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ang_ctl),
        .cfg        (cfg_wr),
        .yaw_rate   (s_yaw_rate),
        .pitch_rate (s_pitch_rate),
        .frame_time (s_frame_time),
        .yaw        (yaw),
        .pitch      (pitch)
    );

    // Launch both angles into the rotation chain.
    assign rot_v[0]       = (state_reg == ocp_pkg::ST_LAUNCH);
    assign rot_d[0].yaw   = ocp_pkg::cordic_seed(yaw);
    assign rot_d[0].pitch = ocp_pkg::cordic_seed(
        {{(ocp_pkg::ANGLE_BITS-ocp_pkg::PITCH_W){pitch[ocp_pkg::PITCH_W-1]}}, pitch});

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        ocp_rot_cell #(
            .SHIFT (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_vld   (rot_v[g]),
            .in_data  (rot_d[g]),
            .out_vld  (rot_v[g+1]),
            .out_data (rot_d[g+1])
        );
    end

    ocp_product u_product (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (mul_ctl),
        .sts         (mul_sts),
        .rot         (rot_d[CORDIC_STAGES]),
        .distance    (dist_reg),
        .tgt_x       (tx_reg),
        .tgt_y       (ty_reg),
        .tgt_z       (tz_reg),
        .yaw         (yaw),
        .pitch       (pitch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_pos_z     (m_pos_z),
        .m_cur_yaw   (m_cur_yaw),
        .m_cur_pitch (m_cur_pitch)
    );

endmodule
